// ===== hdl/tdt_pkg.sv =====
`default_nettype none

package tdt_pkg;

  localparam int unsigned REQ_W       = 2;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned TICK_W      = 32;
  localparam int unsigned MASK_W      = 32;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 104;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_DELAY = 2'd1,
    REQ_START = 2'd2,
    REQ_NOP   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK_RD,
    ST_TICK_WR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [TICK_W-1:0] value;
    logic              zero;
  } dec_result_t;

endpackage

`default_nettype wire

// ===== hdl/tdt_ram.sv =====
`default_nettype none

module tdt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tdt_dec.sv =====
`default_nettype none

module tdt_dec (
  input  wire logic [31:0]         value,
  output tdt_pkg::dec_result_t     result
);

  import tdt_pkg::*;

  logic [TICK_W-1:0] dec_value;

  // A counter already at zero stays there and still counts as expired.
  assign dec_value    = (value == '0) ? '0 : value - TICK_W'(1);
  assign result.value = dec_value;
  assign result.zero  = (dec_value == '0);

endmodule

`default_nettype wire

// ===== hdl/thread_delay_timeout_timers_core.sv =====
`default_nettype none
// Channel | Dir | Handshake                     | Payload
// s_axis  | in  | s_axis_tvalid / s_axis_tready | req_type, thread_slot, delay_ticks
// m_axis  | out | m_axis_tvalid / m_axis_tready | ready_mask, delayed_mask, tick_total,
//         |     |                               | request_error
//
// Delay, start and no-op requests go from acceptance straight to the final step, which loads the result.
// A tick walks through every slot in turn: it reads, decrements and writes back each
// delayed slot's timeout through the single timeout RAM and one shared decrementer.
// Reset clears all masks and the tick count; the timeout RAM needs no clearing.
// The input is not ready while a request is being worked on; a finished result that
// is not taken holds the block in its final step and the next request waits.

module thread_delay_timeout_timers_core #(
  parameter int unsigned THREAD_SLOTS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [1:0] req_type, [7:2] thread_slot, [39:8] delay_ticks
  input  wire logic [tdt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [31:0] ready_mask, [63:32] delayed_mask, [95:64] tick_total,
  // [96] request_error, [103:97] zero
  output logic      [tdt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  import tdt_pkg::*;

  localparam int unsigned IDX_W = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;

  state_t                  state, state_next;
  logic [IDX_W-1:0]        idx, idx_next;
  logic [THREAD_SLOTS-1:0] ready_bits, ready_bits_next;
  logic [THREAD_SLOTS-1:0] delayed_bits, delayed_bits_next;
  logic [THREAD_SLOTS-1:0] registered_bits, registered_bits_next;
  logic [TICK_W-1:0]       tick_counter, tick_counter_next;
  logic                    err_flag, err_flag_next;
  logic                    out_valid, out_valid_next;
  logic [OUT_TDATA_W-1:0]  out_data;
  logic                    out_load;

  req_type_t               in_req;
  logic [SLOT_W-1:0]       in_slot;
  logic [SLOT_W-1:0]       in_slot_m1;
  logic [IDX_W-1:0]        in_idx;
  logic [TICK_W-1:0]       in_ticks;
  logic                    in_slot_ok;
  logic                    in_accept;
  logic [THREAD_SLOTS-1:0] in_onehot;
  logic [THREAD_SLOTS-1:0] walk_bit;
  logic                    walk_last;

  logic                    ram_wr_en;
  logic [IDX_W-1:0]        ram_wr_addr;
  logic [TICK_W-1:0]       ram_wr_data;
  logic                    ram_rd_en;
  logic [TICK_W-1:0]       ram_rd_data;
  dec_result_t             dec;

  assign in_req     = req_type_t'(s_axis_tdata[1:0]);
  assign in_slot    = s_axis_tdata[7:2];
  assign in_ticks   = s_axis_tdata[39:8];
  assign in_slot_m1 = in_slot - SLOT_W'(1);
  assign in_idx     = in_slot_m1[IDX_W-1:0];
  assign in_slot_ok = (in_slot != '0) && (in_slot <= SLOT_W'(THREAD_SLOTS));
  assign walk_last  = (idx == IDX_W'(THREAD_SLOTS - 1));

  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_comb begin
    in_onehot         = '0;
    in_onehot[in_idx] = 1'b1;
    walk_bit          = '0;
    walk_bit[idx]     = 1'b1;
  end

  tdt_ram #(
    .WIDTH (TICK_W),
    .DEPTH (THREAD_SLOTS),
    .AW    (IDX_W)
  ) u_timeout_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (idx),
    .rd_data (ram_rd_data)
  );

  tdt_dec u_dec (
    .value  (ram_rd_data),
    .result (dec)
  );

  always_comb begin
    state_next           = state;
    idx_next             = idx;
    ready_bits_next      = ready_bits;
    delayed_bits_next    = delayed_bits;
    registered_bits_next = registered_bits;
    tick_counter_next    = tick_counter;
    err_flag_next        = err_flag;
    ram_wr_en            = 1'b0;
    ram_wr_addr          = in_idx;
    ram_wr_data          = in_ticks;
    ram_rd_en            = 1'b0;
    out_load             = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          err_flag_next = 1'b0;
          state_next    = ST_FINISH;
          unique case (in_req)
            REQ_TICK: begin
              idx_next   = '0;
              state_next = ST_TICK_RD;
            end
            REQ_DELAY: begin
              if (in_slot_ok && ((registered_bits & in_onehot) != '0)) begin
                ram_wr_en = 1'b1;
                if (in_ticks == '0) begin
                  ready_bits_next   = ready_bits | in_onehot;
                  delayed_bits_next = delayed_bits & ~in_onehot;
                end else begin
                  ready_bits_next   = ready_bits & ~in_onehot;
                  delayed_bits_next = delayed_bits | in_onehot;
                end
              end
            end
            REQ_START: begin
              if (!in_slot_ok || ((registered_bits & in_onehot) != '0)) begin
                err_flag_next = 1'b1;
              end else begin
                registered_bits_next = registered_bits | in_onehot;
                ready_bits_next      = ready_bits | in_onehot;
              end
            end
            REQ_NOP: begin
              state_next = ST_FINISH;
            end
          endcase
        end
      end
      ST_TICK_RD: begin
        if ((delayed_bits & walk_bit) != '0) begin
          ram_rd_en  = 1'b1;
          state_next = ST_TICK_WR;
        end else if (walk_last) begin
          tick_counter_next = tick_counter + TICK_W'(1);
          state_next        = ST_FINISH;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      ST_TICK_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx;
        ram_wr_data = dec.value;
        if (dec.zero) begin
          ready_bits_next   = ready_bits | walk_bit;
          delayed_bits_next = delayed_bits & ~walk_bit;
        end
        if (walk_last) begin
          tick_counter_next = tick_counter + TICK_W'(1);
          state_next        = ST_FINISH;
        end else begin
          idx_next   = idx + IDX_W'(1);
          state_next = ST_TICK_RD;
        end
      end
      ST_FINISH: begin
        if (!out_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase

    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      idx             <= '0;
      ready_bits      <= '0;
      delayed_bits    <= '0;
      registered_bits <= '0;
      tick_counter    <= '0;
      err_flag        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state           <= state_next;
      idx             <= idx_next;
      ready_bits      <= ready_bits_next;
      delayed_bits    <= delayed_bits_next;
      registered_bits <= registered_bits_next;
      tick_counter    <= tick_counter_next;
      err_flag        <= err_flag_next;
      out_valid       <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {7'b0, err_flag, tick_counter, MASK_W'(delayed_bits), MASK_W'(ready_bits)};
    end
  end

  a_ready_delayed_disjoint: assert property (@(posedge clk) disable iff (rst)
    (ready_bits & delayed_bits) == '0)
    else $error("A slot is both ready and delayed.");

  a_delayed_registered: assert property (@(posedge clk) disable iff (rst)
    (delayed_bits & ~registered_bits) == '0)
    else $error("A delayed slot was never started.");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("A request was taken while the previous one was in progress.");

endmodule

`default_nettype wire
